// ----- src/smsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Sliding median spike filter package
// Shared widths, the sorted cell record and the link passed between cells.
// ----------------------------------------------------------------------------
package smsf_pkg;

  localparam int PRICE_W = 32;
  localparam int MED_W   = 33;
  localparam int CNT_W   = 5;

  // One entry of the sorted chain: sample value and its age in transactions.
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] value;
    logic [CNT_W-1:0]   age;
  } cell_t;

  // Handed from each cell to its right neighbor in the same cycle.
  typedef struct packed {
    logic  del_seen;  // the entry to drop sits at this cell or to its left
    logic  gt;        // the compacted entry here is empty or above the new sample
    cell_t shifted;   // the compacted entry here, after the drop
  } link_t;

endpackage

// ----- src/smsf_cell.sv -----
// ----------------------------------------------------------------------------
// Sliding median spike filter cell
// One slot of the sorted window: drops the expiring sample and inserts the
// new one, looking only at its two neighbors.
// ----------------------------------------------------------------------------
module smsf_cell
  import smsf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               upd_i,
  input  logic               clr_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic               del_en_i,
  input  logic [CNT_W-1:0]   del_age_i,
  input  link_t              left_i,
  input  cell_t              right_i,
  output link_t              link_o,
  output cell_t              cell_o
);

  logic               valid_q, valid_d;
  logic [PRICE_W-1:0] value_q, value_d;
  logic [CNT_W-1:0]   age_q, age_d;
  cell_t              own;
  cell_t              comp;
  logic               del_here;
  logic               del_seen;
  logic               gt;

  assign own = '{valid: valid_q, value: value_q, age: age_q};

  always_comb begin
    del_here = del_en_i && valid_q && (age_q == del_age_i);
    del_seen = left_i.del_seen || del_here;
    // After the drop, everything right of the dropped entry moves left by one.
    comp = del_seen ? right_i : own;
    gt   = !comp.valid || (comp.value > price_i);
    if (gt) begin
      if (!left_i.gt) begin
        valid_d = 1'b1;
        value_d = price_i;
        age_d   = '0;
      end else begin
        valid_d = left_i.shifted.valid;
        value_d = left_i.shifted.value;
        age_d   = left_i.shifted.age + CNT_W'(1);
      end
    end else begin
      valid_d = comp.valid;
      value_d = comp.value;
      age_d   = comp.age + CNT_W'(1);
    end
  end

  assign link_o = '{del_seen: del_seen, gt: gt, shifted: comp};
  assign cell_o = own;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clr_i) begin
      valid_q <= 1'b0;
    end else if (upd_i) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

endmodule

// ----- src/sliding_median_spike_filter_unit.sv -----
// ----------------------------------------------------------------------------
// Sliding median spike filter
// Running median over the most recent price samples, up to the configured
// window length, kept as a sorted chain of cells, with a flag for samples far
// from the median.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                 Payload
//  input     in         in_valid_i / in_stall_o   price_i
//  output    out        out_valid_o / out_stall_i median_doubled_o, spike_o,
//                                                 fill_level_o
//  config    in         cfg_we_i                  cfg_data_i (window length)
//
// Each transaction has two steps: the cell chain drops the expiring sample and
// inserts the new one, then the middle cells are selected and the spike
// compares done. A new sample is taken only once the output register is free
// or being emptied, so a stalled output holds the input side.
// Reset empties the window and sets the window length to 5; a configuration
// write empties it as well.
// ----------------------------------------------------------------------------
module sliding_median_spike_filter_unit
  import smsf_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [PRICE_W-1:0] price_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [MED_W-1:0]   median_doubled_o,
  output logic               spike_o,
  output logic [CNT_W-1:0]   fill_level_o,
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_data_i
);

  localparam int IdxW = ($clog2(MAX_WINDOW) > CNT_W) ? $clog2(MAX_WINDOW) : CNT_W;
  localparam logic [CNT_W-1:0] MaxSize =
      (MAX_WINDOW > (2 ** CNT_W) - 1) ? CNT_W'((2 ** CNT_W) - 1) : CNT_W'(MAX_WINDOW);
  localparam logic [CNT_W-1:0] ResetSize = (MaxSize < CNT_W'(5)) ? MaxSize : CNT_W'(5);

  typedef enum logic {ST_IDLE, ST_CALC} state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   wsize_q;
  logic [CNT_W-1:0]   count_q;
  logic [PRICE_W-1:0] price_q;
  logic               out_valid_q;
  logic [MED_W-1:0]   med_q;
  logic               spike_q;
  logic [CNT_W-1:0]   fill_q;

  logic               accept;
  logic [CNT_W-1:0]   eff_size;
  logic               full;
  logic [CNT_W-1:0]   del_age;
  link_t              links [MAX_WINDOW+1];
  cell_t              cells [MAX_WINDOW];
  cell_t              cells_right [MAX_WINDOW];
  logic [IdxW-1:0]    hi_idx;
  logic [IdxW-1:0]    lo_idx;
  logic [PRICE_W-1:0] hi_val;
  logic [PRICE_W-1:0] lo_val;
  logic [MED_W-1:0]   med2;
  logic               spike;

  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    if (wsize_q == '0) begin
      eff_size = CNT_W'(1);
    end else if (wsize_q > MaxSize) begin
      eff_size = MaxSize;
    end else begin
      eff_size = wsize_q;
    end
  end

  // Once full, the sample whose age reaches size-1 leaves as the new one enters.
  assign full    = (count_q == eff_size);
  assign del_age = eff_size - CNT_W'(1);

  assign links[0] = '{del_seen: 1'b0, gt: 1'b0, shifted: '0};

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    if (i == MAX_WINDOW - 1) begin : g_last
      assign cells_right[i] = '0;
    end else begin : g_mid
      assign cells_right[i] = cells[i+1];
    end

    smsf_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .upd_i     (accept),
      .clr_i     (cfg_we_i),
      .price_i   (price_i),
      .del_en_i  (full),
      .del_age_i (del_age),
      .left_i    (links[i]),
      .right_i   (cells_right[i]),
      .link_o    (links[i+1]),
      .cell_o    (cells[i])
    );
  end

  // Median select: the middle cell, or the middle pair for an even fill.
  always_comb begin
    hi_idx = IdxW'(count_q >> 1);
    lo_idx = hi_idx - IdxW'(1);
    hi_val = '0;
    lo_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (hi_idx == IdxW'(i)) begin
        hi_val = cells[i].value;
      end
      if (lo_idx == IdxW'(i)) begin
        lo_val = cells[i].value;
      end
    end
    if (count_q[0]) begin
      med2 = {hi_val, 1'b0};
    end else begin
      med2 = MED_W'(hi_val) + MED_W'(lo_val);
    end
    spike = ({1'b0, price_q} > med2) || ({1'b0, price_q, 2'b00} < {2'b00, med2});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wsize_q     <= ResetSize;
      count_q     <= '0;
      price_q     <= '0;
      out_valid_q <= 1'b0;
      med_q       <= '0;
      spike_q     <= 1'b0;
      fill_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        wsize_q <= cfg_data_i;
        count_q <= '0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            price_q <= price_i;
            if (!full) begin
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          med_q       <= med2;
          spike_q     <= spike;
          fill_q      <= count_q;
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign median_doubled_o = med_q;
  assign spike_o          = spike_q;
  assign fill_level_o     = fill_q;

endmodule

// ----- sim/median_filter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Median filter checker
// Watches the input, output and configuration ports of the sliding median
// spike filter, keeps its own window of samples to work out the doubled
// median, spike flag and fill level of every accepted sample, and compares
// them in order with the results that the block hands out.
// ----------------------------------------------------------------------------
module median_filter_checker
  import smsf_pkg::*;
#(
  parameter int MAX_WINDOW = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [PRICE_W-1:0] price_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [MED_W-1:0]   median_doubled_i,
  input  logic               spike_i,
  input  logic [CNT_W-1:0]   fill_level_i,
  input  logic               cfg_we_i,
  input  logic [CNT_W-1:0]   cfg_data_i,
  output int                 outstanding_o,
  output int                 mismatch_count_o
);

  localparam logic [CNT_W-1:0] WIN_LEN_RESET = 5;
  localparam int               REPORT_LIMIT  = 10;

  typedef struct {
    logic [MED_W-1:0] median_doubled;
    logic             spike;
    logic [CNT_W-1:0] fill_level;
  } median_result_t;

  logic [PRICE_W-1:0] ring [MAX_WINDOW];
  logic [CNT_W-1:0]   win_len;
  int unsigned        held;
  int unsigned        oldest;
  int                 mismatches = 0;
  median_result_t     expected_results [$];

  assign mismatch_count_o = mismatches;

  // Puts one sample into the window and returns what the block must report.
  function automatic median_result_t admit_price(input logic [PRICE_W-1:0] price);
    int unsigned        span;
    int unsigned        slot;
    int                 n;
    int                 j;
    logic [PRICE_W-1:0] ordered [MAX_WINDOW];
    logic [PRICE_W-1:0] key;
    logic [MED_W-1:0]   med2;
    logic [63:0]        p64;
    logic [63:0]        m64;
    median_result_t     r;
    span = win_len;
    if (span < 1) span = 1;
    if (span > MAX_WINDOW) span = MAX_WINDOW;
    if (held > span) held = span;
    if (oldest >= span) oldest = 0;
    if (held < span) begin
      slot = oldest + held;
      if (slot >= span) slot -= span;
      ring[slot] = price;
      held++;
    end else begin
      ring[oldest] = price;
      oldest++;
      if (oldest >= span) oldest = 0;
    end
    n = held;
    for (int i = 0; i < n; i++) ordered[i] = ring[i];
    for (int i = 1; i < n; i++) begin
      key = ordered[i];
      j = i;
      while (j > 0 && ordered[j-1] > key) begin
        ordered[j] = ordered[j-1];
        j--;
      end
      ordered[j] = key;
    end
    if (n % 2 == 1) med2 = MED_W'(ordered[n/2]) << 1;
    else med2 = MED_W'(ordered[n/2]) + MED_W'(ordered[n/2-1]);
    // Above twice the median, or four times the price below the doubled median.
    p64 = 64'(price);
    m64 = 64'(med2);
    r.median_doubled = med2;
    r.spike          = (p64 > m64) || ((p64 << 2) < m64);
    r.fill_level     = CNT_W'(n);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < REPORT_LIMIT)
      $display("%t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    median_result_t want;
    if (!rst_ni) begin
      win_len = WIN_LEN_RESET;
      held    = 0;
      oldest  = 0;
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      // Any write to the window length empties the window, even the same value.
      if (cfg_we_i) begin
        win_len = cfg_data_i;
        held    = 0;
        oldest  = 0;
      end
      if (in_valid_i && !in_stall_i)
        expected_results.insert(expected_results.size(), admit_price(price_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected transaction, median", '0, 64'(median_doubled_i));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (median_doubled_i !== want.median_doubled)
            report_mismatch("median_doubled", 64'(want.median_doubled),
                            64'(median_doubled_i));
          if (spike_i !== want.spike)
            report_mismatch("spike", 64'(want.spike), 64'(spike_i));
          if (fill_level_i !== want.fill_level)
            report_mismatch("fill_level", 64'(want.fill_level), 64'(fill_level_i));
        end
      end
      outstanding_o <= expected_results.size();
    end
  end

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding median spike filter testbench
// Drives price samples in random bursts under several window sizes, with
// a receiver that stalls on its own pattern, and leaves prediction and
// comparison to the checker placed beside the block.
// ----------------------------------------------------------------------------
module testbench;
  import smsf_pkg::*;

  localparam int MAX_WINDOW   = 16;
  localparam int RANDOM_ITEMS = 550;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_valid   = 1'b0;
  logic [PRICE_W-1:0] price      = '0;
  logic               out_stall  = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CNT_W-1:0]   cfg_data   = '0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic [MED_W-1:0]   median_doubled_o;
  logic               spike_o;
  logic [CNT_W-1:0]   fill_level_o;
  int                 outstanding;
  int                 mismatches;
  int                 quiet      = 0;
  int                 burst_left = 0;

  always #1 clk = ~clk;

  sliding_median_spike_filter_unit #(
    .MAX_WINDOW(MAX_WINDOW)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .price_i         (price),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .median_doubled_o(median_doubled_o),
    .spike_o         (spike_o),
    .fill_level_o    (fill_level_o),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data)
  );

  median_filter_checker #(
    .MAX_WINDOW(MAX_WINDOW)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall_o),
    .price_i         (price),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall),
    .median_doubled_i(median_doubled_o),
    .spike_i         (spike_o),
    .fill_level_i    (fill_level_o),
    .cfg_we_i        (cfg_we),
    .cfg_data_i      (cfg_data),
    .outstanding_o   (outstanding),
    .mismatch_count_o(mismatches)
  );

  // Holds the sample until the block accepts it.
  task automatic send_price(input logic [PRICE_W-1:0] p);
    in_valid <= 1'b1;
    price    <= p;
    do @(posedge clk); while (in_stall_o);
  endtask

  task automatic paced_send(input logic [PRICE_W-1:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      case ($urandom_range(0, 5))
        0, 1: gap = 0;
        5: gap = $urandom_range(10, 20);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_price(p);
  endtask

  // Writes the window length once every result is back and the block is quiet.
  task automatic write_win_len(input logic [CNT_W-1:0] size);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= size;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  function automatic logic [PRICE_W-1:0] pick_price(input logic [PRICE_W-1:0] level);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return '0;
      2: return '1;
      3: return level * 3;
      4: return level / 5;
      5: return level;
      default: return level + $urandom_range(0, 64) - 32;
    endcase
  endfunction

  // Receiver stall pattern: quiet stretches, random stalls, periodic and long.
  initial begin : stall_pattern
    int mode;
    int span;
    int period;
    forever begin
      mode   = $urandom_range(0, 3);
      span   = $urandom_range(20, 80);
      period = $urandom_range(2, 5);
      for (int c = 0; c < span; c++) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          2: out_stall <= (c % period == 0);
          default: out_stall <= ((c % 16) < 10);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0]   sizes [5];
    logic [PRICE_W-1:0] level;
    int                 sent;
    int                 phase;
    int                 phase_len;
    sizes = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Window size from reset: fill, slide, spikes above and below, extremes.
    paced_send(32'd100);
    paced_send(32'd100);
    paced_send(32'd250);
    paced_send(32'd10);
    paced_send(32'hFFFF_FFFF);
    paced_send(32'd0);
    paced_send(32'd50);
    paced_send(32'd400);
    // A size of zero acts as a window of one.
    write_win_len(5'd0);
    paced_send(32'hFFFF_FFFF);
    paced_send(32'd1);
    paced_send(32'd0);
    // Writing the same size again still starts a new window.
    write_win_len(5'd2);
    paced_send(32'd3);
    paced_send(32'd5);
    write_win_len(5'd2);
    paced_send(32'd9);
    // Sizes above the limit saturate; the largest doubled median appears here.
    write_win_len(5'd17);
    paced_send(32'hFFFF_FFFF);
    paced_send(32'hFFFF_FFFF);
    paced_send(32'hFFFF_FFFF);
    paced_send(32'd0);
    paced_send(32'd0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      write_win_len(phase < 5 ? sizes[phase] : CNT_W'($urandom_range(0, 31)));
      case ($urandom_range(0, 3))
        0: level = $urandom;
        1: level = $urandom_range(0, 100);
        2: level = 32'hFFFF_FFFF - $urandom_range(0, 1000);
        default: level = $urandom_range(1, 1000000);
      endcase
      phase_len = $urandom_range(20, 60);
      for (int k = 0; k < phase_len; k++) paced_send(pick_price(level));
      sent += phase_len;
      phase++;
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/smsf_pkg.sv
src/smsf_cell.sv
src/sliding_median_spike_filter_unit.sv
sim/median_filter_checker.sv
sim/testbench.sv
